@@ src/mgd_pkg.sv @@
`default_nettype none

package mgd_pkg;

  localparam int unsigned MAX_WIDTH  = 128;
  localparam int unsigned MAX_HEIGHT = 128;
  localparam int unsigned VALUE_BITS = 16;
  localparam int unsigned MIN_DIM    = 4;

  // Column and row positions, and the width of the size registers.
  localparam int unsigned POS_W = $clog2(MAX_WIDTH);
  localparam int unsigned DIM_W = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // Sum of eight neighbors needs three extra bits.
  localparam int unsigned SUM_W = VALUE_BITS + 3;

  localparam logic [VALUE_BITS-1:0] SRC_A_VAL = VALUE_BITS'(3) << (VALUE_BITS - 2);
  localparam logic [VALUE_BITS-1:0] SRC_B_VAL = VALUE_BITS'(1) << (VALUE_BITS - 2);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [POS_W-1:0]      pos_t;
  typedef logic [DIM_W-1:0]      dim_t;

  typedef struct packed {
    logic   walkable;
    value_t b;
    value_t a;
  } cell_t;

  // One line buffer word holds a column of the two rows above.
  typedef struct packed {
    cell_t up2;
    cell_t up1;
  } line_pair_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 3'd0,
    REG_GRID_HEIGHT = 3'd1,
    REG_SRC_A_X     = 3'd2,
    REG_SRC_A_Y     = 3'd3,
    REG_SRC_B_X     = 3'd4,
    REG_SRC_B_Y     = 3'd5
  } cfg_idx_e;

endpackage

`default_nettype wire

@@ src/mgd_in_if.sv @@
`default_nettype none

interface mgd_in_if;
  logic                 valid;
  logic                 ready;
  mgd_pkg::value_t      prev_a;
  mgd_pkg::value_t      prev_b;
  logic                 walkable;

  modport source (output valid, output prev_a, output prev_b, output walkable, input ready);
  modport sink   (input valid, input prev_a, input prev_b, input walkable, output ready);
endinterface

`default_nettype wire

@@ src/mgd_out_if.sv @@
`default_nettype none

interface mgd_out_if;
  logic                 valid;
  logic                 ready;
  mgd_pkg::pos_t        cell_col;
  mgd_pkg::pos_t        cell_row;
  mgd_pkg::value_t      new_a;
  mgd_pkg::value_t      new_b;
  logic                 grid_done;

  modport source (output valid, output cell_col, output cell_row, output new_a,
                  output new_b, output grid_done, input ready);
  modport sink   (input valid, input cell_col, input cell_row, input new_a,
                  input new_b, input grid_done, output ready);
endinterface

`default_nettype wire

@@ src/mgd_line_buf.sv @@
`default_nettype none

module mgd_line_buf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              rd_en_i,
  input  wire mgd_pkg::pos_t     rd_addr_i,
  output mgd_pkg::line_pair_t    rd_data_o,
  input  wire logic              wr_en_i,
  input  wire mgd_pkg::pos_t     wr_addr_i,
  input  wire mgd_pkg::line_pair_t wr_data_i
);

  mgd_pkg::line_pair_t mem_q [mgd_pkg::MAX_WIDTH];
  logic [mgd_pkg::MAX_WIDTH-1:0] vld_q;
  mgd_pkg::line_pair_t rdata_q;
  logic                rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  // A column never written since reset reads as zeros.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire

@@ src/mgd_window.sv @@
`default_nettype none

module mgd_window (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            shift_i,
  input  wire mgd_pkg::cell_t  cur_i,
  input  wire mgd_pkg::cell_t  up1_i,
  input  wire mgd_pkg::cell_t  up2_i,
  output mgd_pkg::value_t      new_a_o,
  output mgd_pkg::value_t      new_b_o
);

  // win_q[k][0] is column c-2 and win_q[k][1] column c-1; row k=0 is r-2.
  mgd_pkg::cell_t win_q [3][2];
  mgd_pkg::cell_t col_in [3];
  logic [mgd_pkg::SUM_W-1:0] sum_a;
  logic [mgd_pkg::SUM_W-1:0] sum_b;

  assign col_in[0] = up2_i;
  assign col_in[1] = up1_i;
  assign col_in[2] = cur_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k][0] <= '0;
        win_q[k][1] <= '0;
      end
    end else if (shift_i) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k][0] <= win_q[k][1];
        win_q[k][1] <= col_in[k];
      end
    end
  end

  // The center cell (row r-1, column c-1) is left out of both sums.
  always_comb begin
    sum_a = '0;
    sum_b = '0;
    for (int k = 0; k < 3; k++) begin
      sum_a = sum_a + mgd_pkg::SUM_W'(win_q[k][0].a) + mgd_pkg::SUM_W'(col_in[k].a);
      sum_b = sum_b + mgd_pkg::SUM_W'(win_q[k][0].b) + mgd_pkg::SUM_W'(col_in[k].b);
    end
    sum_a = sum_a + mgd_pkg::SUM_W'(win_q[0][1].a) + mgd_pkg::SUM_W'(win_q[2][1].a);
    sum_b = sum_b + mgd_pkg::SUM_W'(win_q[0][1].b) + mgd_pkg::SUM_W'(win_q[2][1].b);
  end

  assign new_a_o = win_q[1][1].walkable ? sum_a[mgd_pkg::SUM_W-1:3] : '0;
  assign new_b_o = win_q[1][1].walkable ? sum_b[mgd_pkg::SUM_W-1:3] : '0;

endmodule

`default_nettype wire

@@ src/masked_grid_diffusion_step.sv @@
`default_nettype none

// Masked 3x3 diffusion over a grid streamed in raster order, one cell per clock unless
// the output stalls. A cell is accepted into an input register while the line buffer is
// read at its column; when it leaves that register the stencil sum is formed, the line
// buffer column is rewritten and, for interior cells, a result is loaded into the
// output register, so a result is registered as its lower-right neighbor leaves the
// input register. Throughput is one cell per cycle unless the output stalls, set by the
// single read and single write of the line buffer per cell. Border cells produce no
// result; grid_done marks the final result. Change the configuration only while idle.
module masked_grid_diffusion_step (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [mgd_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire logic [mgd_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  mgd_in_if.sink                                     in_i,
  mgd_out_if.source                                  out_o
);

  // Configuration registers.
  mgd_pkg::dim_t grid_width_q, grid_height_q;
  mgd_pkg::pos_t src_a_x_q, src_a_y_q, src_b_x_q, src_b_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= mgd_pkg::DIM_W'(mgd_pkg::MAX_WIDTH);
      grid_height_q <= mgd_pkg::DIM_W'(mgd_pkg::MAX_HEIGHT);
      src_a_x_q     <= '0;
      src_a_y_q     <= '0;
      src_b_x_q     <= '0;
      src_b_y_q     <= '0;
    end else if (cfg_we_i) begin
      case (mgd_pkg::cfg_idx_e'(cfg_idx_i))
        mgd_pkg::REG_GRID_WIDTH:  grid_width_q  <= cfg_wdata_i[mgd_pkg::DIM_W-1:0];
        mgd_pkg::REG_GRID_HEIGHT: grid_height_q <= cfg_wdata_i[mgd_pkg::DIM_W-1:0];
        mgd_pkg::REG_SRC_A_X:     src_a_x_q     <= cfg_wdata_i[mgd_pkg::POS_W-1:0];
        mgd_pkg::REG_SRC_A_Y:     src_a_y_q     <= cfg_wdata_i[mgd_pkg::POS_W-1:0];
        mgd_pkg::REG_SRC_B_X:     src_b_x_q     <= cfg_wdata_i[mgd_pkg::POS_W-1:0];
        mgd_pkg::REG_SRC_B_Y:     src_b_y_q     <= cfg_wdata_i[mgd_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective grid size, clamped to the supported range.
  mgd_pkg::dim_t w_eff, h_eff;

  always_comb begin
    w_eff = grid_width_q;
    if (grid_width_q < mgd_pkg::DIM_W'(mgd_pkg::MIN_DIM)) begin
      w_eff = mgd_pkg::DIM_W'(mgd_pkg::MIN_DIM);
    end else if (grid_width_q > mgd_pkg::DIM_W'(mgd_pkg::MAX_WIDTH)) begin
      w_eff = mgd_pkg::DIM_W'(mgd_pkg::MAX_WIDTH);
    end
    h_eff = grid_height_q;
    if (grid_height_q < mgd_pkg::DIM_W'(mgd_pkg::MIN_DIM)) begin
      h_eff = mgd_pkg::DIM_W'(mgd_pkg::MIN_DIM);
    end else if (grid_height_q > mgd_pkg::DIM_W'(mgd_pkg::MAX_HEIGHT)) begin
      h_eff = mgd_pkg::DIM_W'(mgd_pkg::MAX_HEIGHT);
    end
  end

  // Position of the next arriving cell.
  mgd_pkg::pos_t col_q, row_q, col_d, row_d;
  mgd_pkg::pos_t cur_col, cur_row;
  mgd_pkg::dim_t row_ext, col_inc, row_inc;
  logic          cur_emit, cur_done;
  mgd_pkg::cell_t cur_cell;

  always_comb begin
    // A stale position left by a size change is folded back into the grid.
    cur_col = col_q;
    row_ext = mgd_pkg::DIM_W'(row_q);
    if (mgd_pkg::DIM_W'(col_q) >= w_eff) begin
      cur_col = '0;
      row_ext = mgd_pkg::DIM_W'(row_q) + mgd_pkg::DIM_W'(1);
    end
    cur_row = (row_ext >= h_eff) ? '0 : row_ext[mgd_pkg::POS_W-1:0];

    col_inc = mgd_pkg::DIM_W'(cur_col) + mgd_pkg::DIM_W'(1);
    row_inc = mgd_pkg::DIM_W'(cur_row) + mgd_pkg::DIM_W'(1);
    col_d   = col_inc[mgd_pkg::POS_W-1:0];
    row_d   = cur_row;
    if (col_inc >= w_eff) begin
      col_d = '0;
      row_d = (row_inc >= h_eff) ? '0 : row_inc[mgd_pkg::POS_W-1:0];
    end

    cur_emit = (cur_col >= mgd_pkg::POS_W'(2))
            && (mgd_pkg::DIM_W'(cur_col) <= w_eff - mgd_pkg::DIM_W'(2))
            && (cur_row >= mgd_pkg::POS_W'(2))
            && (mgd_pkg::DIM_W'(cur_row) <= h_eff - mgd_pkg::DIM_W'(2));
    cur_done = (mgd_pkg::DIM_W'(cur_col) == w_eff - mgd_pkg::DIM_W'(2))
            && (mgd_pkg::DIM_W'(cur_row) == h_eff - mgd_pkg::DIM_W'(2));

    cur_cell.a = (cur_col == src_a_x_q && cur_row == src_a_y_q)
               ? mgd_pkg::SRC_A_VAL : in_i.prev_a;
    cur_cell.b = (cur_col == src_b_x_q && cur_row == src_b_y_q)
               ? mgd_pkg::SRC_B_VAL : in_i.prev_b;
    cur_cell.walkable = in_i.walkable;
  end

  // Input register stage.
  logic           s1_valid_q, s1_emit_q, s1_done_q;
  mgd_pkg::cell_t s1_cell_q;
  mgd_pkg::pos_t  s1_col_q, s1_row_q;
  logic           s1_adv, in_acc, in_rdy;

  // Output register.
  logic            out_valid_q, out_done_q;
  mgd_pkg::pos_t   out_col_q, out_row_q;
  mgd_pkg::value_t out_a_q, out_b_q;

  assign s1_adv = s1_valid_q && (!s1_emit_q || !out_valid_q || out_o.ready);
  assign in_rdy = !s1_valid_q || s1_adv;
  assign in_acc = in_i.valid && in_rdy;
  assign in_i.ready = in_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        col_q      <= col_d;
        row_q      <= row_d;
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cell_q <= cur_cell;
      s1_col_q  <= cur_col;
      s1_row_q  <= cur_row;
      s1_emit_q <= cur_emit;
      s1_done_q <= cur_done;
    end
  end

  mgd_pkg::line_pair_t lb_rd, lb_wr;
  mgd_pkg::value_t     st_a, st_b;

  // The row above moves down to the second row; the current cell becomes the row above.
  assign lb_wr = {lb_rd.up1, s1_cell_q};

  mgd_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (cur_col),
    .rd_data_o (lb_rd),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_col_q),
    .wr_data_i (lb_wr)
  );

  mgd_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_adv),
    .cur_i   (s1_cell_q),
    .up1_i   (lb_rd.up1),
    .up2_i   (lb_rd.up2),
    .new_a_o (st_a),
    .new_b_o (st_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_emit_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit_q) begin
      out_col_q  <= s1_col_q - mgd_pkg::POS_W'(1);
      out_row_q  <= s1_row_q - mgd_pkg::POS_W'(1);
      out_a_q    <= st_a;
      out_b_q    <= st_b;
      out_done_q <= s1_done_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.cell_col  = out_col_q;
  assign out_o.cell_row  = out_row_q;
  assign out_o.new_a     = out_a_q;
  assign out_o.new_b     = out_b_q;
  assign out_o.grid_done = out_done_q;

  // A cell that leaves the input register with a result always lands in the output.
  a_emit_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_emit_q |=> out_valid_q)
    else $error("interior cell result was dropped");

  // A pending result is never overwritten by the next one.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !(s1_adv && s1_emit_q))
    else $error("pending result overwritten");

  // Produced cells are interior, so neither coordinate is zero.
  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_col_q != '0) && (out_row_q != '0))
    else $error("border cell produced a result");

endmodule

`default_nettype wire
